// ----- hw/rtl/ppc_pkg.sv -----
// Shared constants, codes and types of the pinned page cache controller.
package ppc_pkg;
   localparam int SLOTS = 64;
   localparam int PIN_BITS = 8;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam int PAGE_BITS = 31;
   localparam int FSLOT_BITS = 6;
   localparam int CFG_BITS = 7;
   localparam int META_BITS = PIN_BITS + 1;
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   typedef enum logic [1:0] {
      ACT_FETCH = 2'd0,
      ACT_DROP = 2'd1,
      ACT_MARK = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_GRANT = 3'd0,
      KIND_LOAD = 3'd1,
      KIND_WRITEBACK = 3'd2,
      KIND_DONE = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK = 3'd0,
      STAT_ALL_PINNED = 3'd1,
      STAT_NOT_PINNED = 3'd2,
      STAT_PIN_FULL = 3'd3,
      STAT_UNUSED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HIT_RD, ST_HIT_CHK, ST_MISS, ST_EVC_RD, ST_EVC_CHK, ST_LOAD,
      ST_SLOT_RD, ST_SLOT_CHK, ST_FL_RD, ST_FL_CHK, ST_FL_END
   } state_type;

   typedef struct packed {
      action_type action;
      logic [PAGE_BITS-1:0] page;
      logic [FSLOT_BITS-1:0] slot;
   } item_type;

   typedef struct packed {
      kind_type kind;
      status_type status;
      logic [FSLOT_BITS-1:0] slot;
      logic [PAGE_BITS-1:0] page;
      logic last;
   } rsp_type;
endpackage

// ----- hw/rtl/ppc_ram.sv -----
// Generic single write port RAM with a registered read port.
module ppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/ppc_front.sv -----
// Front part: accepts request items, decodes the action and queues them.
module ppc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [30:0]       req_page_number,
   input  logic [5:0]        req_slot,
   output logic              q_valid,
   output ppc_pkg::item_type q_item,
   input  logic              q_pop
);
   import ppc_pkg::*;

   item_type ent_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;
   item_type new_item;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_pop && q_valid;
   assign q_item = ent_ff[rd_ptr_ff];

   always_comb begin
      new_item.action = action_type'(req_action);
      new_item.page = req_page_number;
      new_item.slot = req_slot;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule

// ----- hw/rtl/ppc_back.sv -----
// Back part: tag search, pin count updates, eviction, flush and result register.
module ppc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  ppc_pkg::item_type          q_item,
   output logic                       q_pop,
   input  logic [ppc_pkg::CNT_BITS-1:0] usable,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ppc_pkg::rsp_type           rsp
);
   import ppc_pkg::*;

   state_type state_ff, state_in;
   item_type item_ff, item_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in, filled_ff, filled_in;
   logic [SLOT_BITS-1:0] vic_ff, vic_in;
   logic pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pend_slot_ff, pend_slot_in;
   logic [PAGE_BITS-1:0] pend_page_ff, pend_page_in;
   logic [SLOTS-1:0] vld_ff, vld_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, emit;

   logic tag_we, meta_we;
   logic [SLOT_BITS-1:0] tag_waddr, meta_waddr, rd_addr;
   logic [PAGE_BITS-1:0] tag_wdata, tag_rd;
   logic [META_BITS-1:0] meta_wdata, meta_rd, meta;
   logic [PIN_BITS-1:0] pin;
   logic chg, out_free;
   logic [CNT_BITS-1:0] idx_next;

   assign rd_addr = idx_ff[SLOT_BITS-1:0];

   ppc_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
      .rd_addr(rd_addr), .rd_data(tag_rd)
   );

   ppc_ram #(.WIDTH(META_BITS), .DEPTH(SLOTS)) u_meta_ram (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
      .rd_addr(rd_addr), .rd_data(meta_rd)
   );

   assign meta = vld_ff[rd_addr] ? meta_rd : '0;
   assign pin = meta[PIN_BITS-1:0];
   assign chg = meta[PIN_BITS];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_next = idx_ff + CNT_BITS'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      idx_in = idx_ff;
      filled_in = filled_ff;
      vic_in = vic_ff;
      pend_in = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_page_in = pend_page_ff;
      vld_in = vld_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      rsp_in = '{kind: KIND_DONE, status: STAT_OK, slot: '0, page: '0, last: 1'b1};
      tag_we = 1'b0;
      tag_waddr = rd_addr;
      tag_wdata = item_ff.page;
      meta_we = 1'b0;
      meta_waddr = rd_addr;
      meta_wdata = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               item_in = q_item;
               idx_in = '0;
               unique case (q_item.action)
                  ACT_FETCH: state_in = (filled_ff == '0) ? ST_MISS : ST_HIT_RD;
                  ACT_DROP, ACT_MARK: begin
                     idx_in = CNT_BITS'(q_item.slot);
                     state_in = ST_SLOT_RD;
                  end
                  ACT_FLUSH: state_in = (filled_ff == '0) ? ST_FL_END : ST_FL_RD;
               endcase
            end
         end
         ST_HIT_RD: state_in = ST_HIT_CHK;
         ST_HIT_CHK: begin
            if (tag_rd == item_ff.page) begin
               if (out_free) begin
                  emit = 1'b1;
                  rsp_in.slot = FSLOT_BITS'(rd_addr);
                  if (pin == PIN_MAX) begin
                     rsp_in.kind = KIND_ERROR;
                     rsp_in.status = STAT_PIN_FULL;
                  end else begin
                     rsp_in.kind = KIND_GRANT;
                     meta_we = 1'b1;
                     meta_wdata = {chg, pin + PIN_BITS'(1)};
                     vld_in[rd_addr] = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end else if (idx_next == filled_ff) begin
               state_in = ST_MISS;
            end else begin
               idx_in = idx_next;
               state_in = ST_HIT_RD;
            end
         end
         ST_MISS: begin
            if (filled_ff < usable) begin
               if (out_free) begin
                  emit = 1'b1;
                  rsp_in.kind = KIND_LOAD;
                  rsp_in.slot = FSLOT_BITS'(filled_ff);
                  rsp_in.page = item_ff.page;
                  tag_we = 1'b1;
                  tag_waddr = filled_ff[SLOT_BITS-1:0];
                  meta_we = 1'b1;
                  meta_waddr = filled_ff[SLOT_BITS-1:0];
                  meta_wdata = {1'b0, PIN_BITS'(1)};
                  vld_in[filled_ff[SLOT_BITS-1:0]] = 1'b1;
                  filled_in = filled_ff + CNT_BITS'(1);
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = '0;
               state_in = ST_EVC_RD;
            end
         end
         ST_EVC_RD: state_in = ST_EVC_CHK;
         ST_EVC_CHK: begin
            if (pin == '0) begin
               if (out_free) begin
                  emit = 1'b1;
                  rsp_in.slot = FSLOT_BITS'(rd_addr);
                  tag_we = 1'b1;
                  meta_we = 1'b1;
                  meta_wdata = {1'b0, PIN_BITS'(1)};
                  vld_in[rd_addr] = 1'b1;
                  if (chg) begin
                     rsp_in.kind = KIND_WRITEBACK;
                     rsp_in.page = tag_rd;
                     rsp_in.last = 1'b0;
                     vic_in = rd_addr;
                     state_in = ST_LOAD;
                  end else begin
                     rsp_in.kind = KIND_LOAD;
                     rsp_in.page = item_ff.page;
                     state_in = ST_IDLE;
                  end
               end
            end else if (idx_next == usable) begin
               if (out_free) begin
                  emit = 1'b1;
                  rsp_in.kind = KIND_ERROR;
                  rsp_in.status = STAT_ALL_PINNED;
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_next;
               state_in = ST_EVC_RD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               emit = 1'b1;
               rsp_in.kind = KIND_LOAD;
               rsp_in.slot = FSLOT_BITS'(vic_ff);
               rsp_in.page = item_ff.page;
               state_in = ST_IDLE;
            end
         end
         ST_SLOT_RD: state_in = ST_SLOT_CHK;
         ST_SLOT_CHK: begin
            if (out_free) begin
               emit = 1'b1;
               rsp_in.slot = item_ff.slot;
               state_in = ST_IDLE;
               if (int'(item_ff.slot) >= int'(filled_ff)) begin
                  rsp_in.kind = KIND_ERROR;
                  rsp_in.status = STAT_UNUSED;
               end else if (item_ff.action == ACT_DROP) begin
                  if (pin == '0) begin
                     rsp_in.kind = KIND_ERROR;
                     rsp_in.status = STAT_NOT_PINNED;
                  end else begin
                     meta_we = 1'b1;
                     meta_wdata = {chg, pin - PIN_BITS'(1)};
                     vld_in[rd_addr] = 1'b1;
                  end
               end else begin
                  meta_we = 1'b1;
                  meta_wdata = {1'b1, pin};
                  vld_in[rd_addr] = 1'b1;
               end
            end
         end
         ST_FL_RD: state_in = ST_FL_CHK;
         ST_FL_CHK: begin
            if (!(chg && pend_ff && !out_free)) begin
               if (chg) begin
                  if (pend_ff) begin
                     emit = 1'b1;
                     rsp_in.kind = KIND_WRITEBACK;
                     rsp_in.slot = FSLOT_BITS'(pend_slot_ff);
                     rsp_in.page = pend_page_ff;
                     rsp_in.last = 1'b0;
                  end
                  pend_in = 1'b1;
                  pend_slot_in = rd_addr;
                  pend_page_in = tag_rd;
                  meta_we = 1'b1;
                  meta_wdata = {1'b0, pin};
                  vld_in[rd_addr] = 1'b1;
               end
               if (idx_next == filled_ff) begin
                  state_in = ST_FL_END;
               end else begin
                  idx_in = idx_next;
                  state_in = ST_FL_RD;
               end
            end
         end
         ST_FL_END: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_ff) begin
                  rsp_in.kind = KIND_WRITEBACK;
                  rsp_in.slot = FSLOT_BITS'(pend_slot_ff);
                  rsp_in.page = pend_page_ff;
               end
               pend_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         filled_ff <= '0;
         pend_ff <= 1'b0;
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         filled_ff <= filled_in;
         pend_ff <= pend_in;
         vld_ff <= vld_in;
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff <= idx_in;
      vic_ff <= vic_in;
      pend_slot_ff <= pend_slot_in;
      pend_page_ff <= pend_page_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end
endmodule

// ----- hw/rtl/pinned_page_cache_controller_top.sv -----
// Top level of the pinned page cache controller.
// A two-item queue takes requests while the back end handles one item at a time with a tag
// RAM and a pin and changed-flag RAM of registered read; each slot visited passes through a
// read state and a check state. A fetch searches the filled slots up to the hit; on a miss
// it takes a free usable slot, or else examines slots for an unpinned victim, writing back a
// changed victim before the load. Drop and mark read the named slot, and a flush visits
// every filled slot. Results leave through a single output register, and a stalled result
// holds back the next one until it is taken.
module pinned_page_cache_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [30:0] req_page_number,
   input  logic [5:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_out_slot,
   output logic [30:0] rsp_out_page,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import ppc_pkg::*;

   logic [CFG_BITS-1:0] slots_in_use_ff;
   logic [CNT_BITS-1:0] usable;
   logic q_valid, q_pop;
   item_type q_item;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= CFG_BITS'(64);
      end else if (csr_wr_en) begin
         slots_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (slots_in_use_ff == '0) begin
         usable = CNT_BITS'(1);
      end else if (int'(slots_in_use_ff) > SLOTS) begin
         usable = CNT_BITS'(SLOTS);
      end else begin
         usable = CNT_BITS'(slots_in_use_ff);
      end
   end

   ppc_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_page_number(req_page_number), .req_slot(req_slot),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   ppc_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .usable(usable), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   assign rsp_kind = rsp.kind;
   assign rsp_status = rsp.status;
   assign rsp_out_slot = rsp.slot;
   assign rsp_out_page = rsp.page;
   assign rsp_last = rsp.last;

   a_status_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_status == STAT_OK)
      else $error("Nonzero status on a result that is not an error.");

   a_no_page_on_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_GRANT || rsp_kind == KIND_DONE ||
                    rsp_kind == KIND_ERROR) |-> rsp_out_page == '0)
      else $error("Page number on a grant, done or error result.");

   a_load_ends_writeback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_LOAD |-> rsp_last)
      else $error("A load request was not the final result of its item.");
endmodule
